// ----- src/gqi_pkg.sv -----
// ----------------------------------------------------------------------------
// gqi_pkg
// shared types and constants of the gyro quaternion integrator
// ----------------------------------------------------------------------------
package gqi_pkg;

   // request: one three-axis gyro sample, signed Q6.26
   typedef struct packed {
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
   } req_type;

   // response: updated attitude, signed Q2.30, and renormalize flag
   typedef struct packed {
      logic signed [31:0] att_w;
      logic signed [31:0] att_x;
      logic signed [31:0] att_y;
      logic signed [31:0] att_z;
      logic               renormalized;
   } rsp_type;

   // command and status of the shift-subtract unit
   typedef struct packed {
      logic start;
      logic op_sqrt;
   } sd_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic ovf;
   } sd_sts_type;

   // one step of the hamilton product schedule
   typedef struct packed {
      logic [1:0] dst;
      logic [1:0] qsel;
      logic [1:0] dsel;
      logic       neg;
   } prod_step_type;

   localparam logic signed [31:0] ONE_Q30      = 32'sh4000_0000;
   localparam logic [31:0]        PERIOD_RESET = 32'd4294967;
   localparam logic [63:0]        BAND_HI      = 64'd291112679913228861;
   localparam logic [63:0]        BAND_LO      = 64'd285348072390194627;
   localparam logic [3:0]         PROD_LAST    = 4'd11;

   // component index: 0 w, 1 x, 2 y, 3 z; increment index: 0 x, 1 y, 2 z
   function automatic prod_step_type prod_step(input logic [3:0] k);
      prod_step_type s;
      case (k)
         4'd0:    s = '{dst: 2'd0, qsel: 2'd1, dsel: 2'd0, neg: 1'b1};
         4'd1:    s = '{dst: 2'd0, qsel: 2'd2, dsel: 2'd1, neg: 1'b1};
         4'd2:    s = '{dst: 2'd0, qsel: 2'd3, dsel: 2'd2, neg: 1'b1};
         4'd3:    s = '{dst: 2'd1, qsel: 2'd0, dsel: 2'd0, neg: 1'b0};
         4'd4:    s = '{dst: 2'd1, qsel: 2'd2, dsel: 2'd2, neg: 1'b0};
         4'd5:    s = '{dst: 2'd1, qsel: 2'd3, dsel: 2'd1, neg: 1'b1};
         4'd6:    s = '{dst: 2'd2, qsel: 2'd0, dsel: 2'd1, neg: 1'b0};
         4'd7:    s = '{dst: 2'd2, qsel: 2'd1, dsel: 2'd2, neg: 1'b1};
         4'd8:    s = '{dst: 2'd2, qsel: 2'd3, dsel: 2'd0, neg: 1'b0};
         4'd9:    s = '{dst: 2'd3, qsel: 2'd0, dsel: 2'd2, neg: 1'b0};
         4'd10:   s = '{dst: 2'd3, qsel: 2'd1, dsel: 2'd1, neg: 1'b0};
         4'd11:   s = '{dst: 2'd3, qsel: 2'd2, dsel: 2'd0, neg: 1'b1};
         default: s = '{dst: 2'd0, qsel: 2'd0, dsel: 2'd0, neg: 1'b0};
      endcase
      return s;
   endfunction

endpackage

// ----- src/gqi_mul.sv -----
// ----------------------------------------------------------------------------
// gqi_mul
// shared signed 33x33 multiplier with registered product
// ----------------------------------------------------------------------------
module gqi_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [65:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ----- src/gqi_root_div.sv -----
// ----------------------------------------------------------------------------
// gqi_root_div
// iterative shift-subtract unit: 32-bit floor square root or 32-bit divide
// ----------------------------------------------------------------------------
module gqi_root_div (
   input  logic               clock,
   input  logic               reset,
   input  gqi_pkg::sd_cmd_type cmd,
   input  logic [63:0]        operand,
   input  logic [31:0]        divisor,
   output gqi_pkg::sd_sts_type sts,
   output logic [31:0]        result
);

   logic [35:0] rem_ff, rem_in;
   logic [63:0] src_ff, src_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic        ovf_ff, ovf_in;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        ge;

   // one compare-subtract per cycle, shared by both operations
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff[33:0], src_ff[63:62]};
         trial  = {2'b00, res_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[34:0], src_ff[63]};
         trial  = {4'b0000, div_ff};
      end
      ge = (rem_sh >= trial);
   end

   always_comb begin
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      ovf_in  = ovf_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         res_in  = '0;
         sqrt_in = cmd.op_sqrt;
         div_in  = divisor;
         if (cmd.op_sqrt) begin
            rem_in = '0;
            src_in = operand;
            ovf_in = 1'b0;
         end else begin
            rem_in = {4'b0000, operand[63:32]};
            src_in = {operand[31:0], 32'b0};
            ovf_in = (operand[63:32] >= divisor);
         end
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - trial) : rem_sh;
         src_in = sqrt_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         res_in = {res_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      sqrt_ff <= sqrt_in;
      ovf_ff  <= ovf_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.ovf  = ovf_ff;
   assign result   = res_ff;

endmodule

// ----- src/gyro_quaternion_integrator.sv -----
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator
// first-order attitude quaternion integration from three-axis gyro samples
// ----------------------------------------------------------------------------
// Holds an attitude quaternion (Q2.30, identity after reset) and, for every
// gyro request (Q6.26 rad/s), multiplies it by the increment
// (1, rate*dt/2 per axis) with dt from csr_wr_data (unsigned Q0.32 seconds).
// When the squared magnitude leaves 0.99..1.01 and its root is nonzero, each
// component is divided by the magnitude and renormalized is set. One request
// is processed at a time: req_stall is high from acceptance until the
// response is loaded. All multiplies go through one 33x33 multiplier with a
// registered product (3 increment, 12 product and 4 square multiplies per
// request); with renormalization the shared shift-subtract unit adds the
// square root and one divide per component. The response sits in an output
// register, so the next request is accepted while it waits on rsp_stall.
// ----------------------------------------------------------------------------
module gyro_quaternion_integrator #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gqi_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gqi_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   // saturation bounds; widths above 32 act as 32
   localparam int CW_EFF = (COMPONENT_WIDTH > 32) ? 32 : COMPONENT_WIDTH;
   localparam logic signed [65:0] SAT_MAX = (66'sd1 <<< (CW_EFF - 1)) - 66'sd1;
   localparam logic signed [65:0] SAT_MIN = -SAT_MAX - 66'sd1;
   localparam logic signed [65:0] HALF_29 = 66'sd1 <<< 28;
   localparam logic signed [65:0] HALF_30 = 66'sd1 <<< 29;
   localparam logic signed [65:0] BIG     = 66'sd1 <<< 40;

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INC    = 4'd1;
   localparam logic [3:0] S_INC_W  = 4'd2;
   localparam logic [3:0] S_PROD   = 4'd3;
   localparam logic [3:0] S_PROD_W = 4'd4;
   localparam logic [3:0] S_SAT    = 4'd5;
   localparam logic [3:0] S_SQ     = 4'd6;
   localparam logic [3:0] S_SQ_W   = 4'd7;
   localparam logic [3:0] S_BAND   = 4'd8;
   localparam logic [3:0] S_SQRT   = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_DIV_W  = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] c;
      if (v > SAT_MAX) begin
         c = SAT_MAX;
      end else if (v < SAT_MIN) begin
         c = SAT_MIN;
      end else begin
         c = v;
      end
      return c[31:0];
   endfunction

   // state
   logic [3:0]         state_ff, state_in;
   logic [3:0]         idx_ff, idx_in;
   logic [31:0]        period_ff, period_in;
   logic signed [31:0] q_ff [4];
   logic signed [31:0] q_in [4];
   logic signed [31:0] rate_ff [3];
   logic signed [31:0] rate_in [3];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] d_in [3];
   logic signed [39:0] acc_ff [4];
   logic signed [39:0] acc_in [4];
   logic [63:0]        msq_ff, msq_in;
   logic [31:0]        mag_ff, mag_in;
   logic               flag_ff, flag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gqi_pkg::rsp_type   rsp_ff, rsp_in;

   // shared units
   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  mul_p;
   gqi_pkg::sd_cmd_type sd_cmd;
   gqi_pkg::sd_sts_type sd_sts;
   logic [63:0]         sd_operand;
   logic [31:0]         sd_result;

   gqi_pkg::prod_step_type step;
   logic signed [65:0] inc_full;
   logic signed [65:0] prod_full;
   logic signed [39:0] prod_r;
   logic signed [31:0] cur_c;
   logic [31:0]        abs_c;
   logic signed [65:0] div_v;

   logic req_take;
   logic rsp_free;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign step     = gqi_pkg::prod_step(idx_ff);

   // rounding of the two product kinds
   assign inc_full  = (mul_p + HALF_29) >>> 29;
   assign prod_full = (mul_p + HALF_30) >>> 30;
   assign prod_r    = prod_full[39:0];

   // magnitude divide operand: |c| * 2^29 + mag/2
   assign cur_c      = acc_ff[idx_ff[1:0]][31:0];
   assign abs_c      = cur_c[31] ? 32'(-cur_c) : cur_c;
   assign sd_operand = (state_ff == S_BAND) ? msq_ff
                     : (({32'b0, abs_c} << 29) + {33'b0, mag_ff[31:1]});

   // signed quotient, overflow pushed well past the bounds
   always_comb begin
      if (sd_sts.ovf) begin
         div_v = cur_c[31] ? -BIG : BIG;
      end else if (cur_c[31]) begin
         div_v = -$signed({34'b0, sd_result});
      end else begin
         div_v = $signed({34'b0, sd_result});
      end
   end

   // multiplier operand select
   always_comb begin
      case (state_ff)
         S_INC: begin
            mul_a = 33'(rate_ff[idx_ff[1:0]]);
            mul_b = $signed({1'b0, period_ff});
         end
         S_PROD: begin
            mul_a = 33'(q_ff[step.qsel]);
            mul_b = 33'(d_ff[step.dsel]);
         end
         S_SQ: begin
            mul_a = acc_ff[idx_ff[1:0]][32:0];
            mul_b = acc_ff[idx_ff[1:0]][32:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   gqi_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

   assign sd_cmd.start   = (state_ff == S_DIV)
                        || ((state_ff == S_BAND) && ((msq_ff > gqi_pkg::BAND_HI)
                                                  || (msq_ff < gqi_pkg::BAND_LO)));
   assign sd_cmd.op_sqrt = (state_ff == S_BAND);

   gqi_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sd_cmd),
      .operand (sd_operand),
      .divisor (mag_ff),
      .sts     (sd_sts),
      .result  (sd_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      q_in         = q_ff;
      rate_in      = rate_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      msq_in       = msq_ff;
      mag_in       = mag_ff;
      flag_in      = flag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rate_in[0] = req_payload.rate_x;
               rate_in[1] = req_payload.rate_y;
               rate_in[2] = req_payload.rate_z;
               for (int i = 0; i < 4; i++) begin
                  acc_in[i] = 40'(q_ff[i]);
               end
               idx_in   = '0;
               flag_in  = 1'b0;
               state_in = S_INC;
            end
         end
         S_INC: state_in = S_INC_W;
         S_INC_W: begin
            d_in[idx_ff[1:0]] = sat32(inc_full);
            if (idx_ff == 4'd2) begin
               idx_in   = '0;
               state_in = S_PROD;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = S_INC;
            end
         end
         S_PROD: state_in = S_PROD_W;
         S_PROD_W: begin
            acc_in[step.dst] = step.neg ? (acc_ff[step.dst] - prod_r)
                                        : (acc_ff[step.dst] + prod_r);
            if (idx_ff == gqi_pkg::PROD_LAST) begin
               state_in = S_SAT;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = S_PROD;
            end
         end
         S_SAT: begin
            for (int i = 0; i < 4; i++) begin
               acc_in[i] = 40'(sat32(66'(acc_ff[i])));
            end
            idx_in   = '0;
            msq_in   = '0;
            state_in = S_SQ;
         end
         S_SQ: state_in = S_SQ_W;
         S_SQ_W: begin
            msq_in = msq_ff + {2'b00, mul_p[63:2]};
            if (idx_ff == 4'd3) begin
               state_in = S_BAND;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = S_SQ;
            end
         end
         S_BAND: state_in = sd_cmd.start ? S_SQRT : S_OUT;
         S_SQRT: begin
            if (sd_sts.done) begin
               mag_in   = sd_result;
               idx_in   = '0;
               state_in = (sd_result == 32'd0) ? S_OUT : S_DIV;
            end
         end
         S_DIV: state_in = S_DIV_W;
         S_DIV_W: begin
            if (sd_sts.done) begin
               acc_in[idx_ff[1:0]] = 40'(sat32(div_v));
               if (idx_ff == 4'd3) begin
                  flag_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_DIV;
               end
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               for (int i = 0; i < 4; i++) begin
                  q_in[i] = acc_ff[i][31:0];
               end
               rsp_in.att_w        = acc_ff[0][31:0];
               rsp_in.att_x        = acc_ff[1][31:0];
               rsp_in.att_y        = acc_ff[2][31:0];
               rsp_in.att_z        = acc_ff[3][31:0];
               rsp_in.renormalized = flag_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         period_ff    <= gqi_pkg::PERIOD_RESET;
         q_ff[0]      <= gqi_pkg::ONE_Q30;
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         q_ff         <= q_in;
      end
      idx_ff  <= idx_in;
      rate_ff <= rate_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      msq_ff  <= msq_in;
      mag_ff  <= mag_in;
      flag_ff <= flag_in;
      rsp_ff  <= rsp_in;
   end

   // ports
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      sd_cmd.start |-> !sd_sts.busy)
      else $error("shift-subtract unit started while busy");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      sd_sts.done |-> (state_ff == S_SQRT || state_ff == S_DIV_W))
      else $error("unit result arrived outside a wait state");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !sd_sts.busy)
      else $error("unit busy while sequencer idle");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside the output step");

   // first output cycle with the flag set must follow the last divide
   a_flag_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && $past(state_ff) != S_OUT && flag_ff)
         |-> $past(state_ff) == S_DIV_W)
      else $error("renormalize flag without a divide pass");

endmodule

// ----- tb/sv/tb_gyro_quaternion_integrator.sv -----
// ----------------------------------------------------------------------------
// tb_gyro_quaternion_integrator
// self-checking testbench of the gyro quaternion integrator
// ----------------------------------------------------------------------------
// Drives gyro requests under random idling and a long receiver hold-off,
// predicts each updated attitude with a bit-exact fixed-point model of the
// quaternion integration and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_gyro_quaternion_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COMP_MAX = 64'sd2147483647;
   localparam longint COMP_MIN = -64'sd2147483648;

   // expected attitudes in order, plus the attitude integrator model
   class attitude_scoreboard;
      longint quat[4];
      logic [31:0] period;
      gqi_pkg::rsp_type pending[$];
      int errors;
      int checked;
      int renorm_seen;

      function new();
         quat[0] = 64'sd1 << 30;
         quat[1] = 0;
         quat[2] = 0;
         quat[3] = 0;
         period = gqi_pkg::PERIOD_RESET;
         errors = 0;
         checked = 0;
         renorm_seen = 0;
      endfunction

      static function longint fshift(longint v, int n);
         return v >>> n;
      endfunction

      static function longint clamp(longint v);
         if (v > COMP_MAX) return COMP_MAX;
         if (v < COMP_MIN) return COMP_MIN;
         return v;
      endfunction

      static function longint qmul(longint a, longint b);
         return fshift(a * b + (64'sd1 << 29), 30);
      endfunction

      static function longint unsigned root_floor(longint unsigned v);
         longint unsigned res;
         longint unsigned bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      static function longint scale_down(longint c, longint unsigned mag);
         longint unsigned a;
         longint q;
         a = longint'(c < 0 ? -c : c) << 29;
         q = longint'((a + mag / 2) / mag);
         return clamp(c < 0 ? -q : q);
      endfunction

      function void note_request(gqi_pkg::req_type r);
         longint d[3];
         longint n[4];
         longint rates[3];
         longint unsigned msq;
         longint unsigned mag;
         gqi_pkg::rsp_type e;
         rates[0] = r.rate_x;
         rates[1] = r.rate_y;
         rates[2] = r.rate_z;
         for (int i = 0; i < 3; i++)
            d[i] = clamp(fshift(rates[i] * longint'({32'd0, period}) + (64'sd1 << 28), 29));
         n[0] = clamp(quat[0] - qmul(quat[1], d[0]) - qmul(quat[2], d[1])
                      - qmul(quat[3], d[2]));
         n[1] = clamp(quat[1] + qmul(quat[0], d[0]) + qmul(quat[2], d[2])
                      - qmul(quat[3], d[1]));
         n[2] = clamp(quat[2] + qmul(quat[0], d[1]) - qmul(quat[1], d[2])
                      + qmul(quat[3], d[0]));
         n[3] = clamp(quat[3] + qmul(quat[0], d[2]) + qmul(quat[1], d[1])
                      - qmul(quat[2], d[0]));
         msq = 0;
         for (int i = 0; i < 4; i++) msq += longint'(n[i] * n[i]) >> 2;
         e.renormalized = 1'b0;
         if (msq > gqi_pkg::BAND_HI || msq < gqi_pkg::BAND_LO) begin
            mag = root_floor(msq);
            if (mag != 0) begin
               for (int i = 0; i < 4; i++) n[i] = scale_down(n[i], mag);
               e.renormalized = 1'b1;
            end
         end
         for (int i = 0; i < 4; i++) quat[i] = n[i];
         e.att_w = n[0][31:0];
         e.att_x = n[1][31:0];
         e.att_y = n[2][31:0];
         e.att_z = n[3][31:0];
         pending.push_back(e);
      endfunction

      function void check_response(gqi_pkg::rsp_type a);
         gqi_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.renormalized) renorm_seen++;
         if (a.att_w !== e.att_w) begin
            $error("att_w expected %h actual %h", e.att_w, a.att_w); errors++;
         end
         if (a.att_x !== e.att_x) begin
            $error("att_x expected %h actual %h", e.att_x, a.att_x); errors++;
         end
         if (a.att_y !== e.att_y) begin
            $error("att_y expected %h actual %h", e.att_y, a.att_y); errors++;
         end
         if (a.att_z !== e.att_z) begin
            $error("att_z expected %h actual %h", e.att_z, a.att_z); errors++;
         end
         if (a.renormalized !== e.renormalized) begin
            $error("renormalized expected %b actual %b", e.renormalized, a.renormalized);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   gqi_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   gqi_pkg::rsp_type rsp_payload;
   logic csr_wr_en;
   logic [31:0] csr_wr_data;

   attitude_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off;
   int requests_sent;

   gyro_quaternion_integrator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous time limit covering every request plus stalls
   initial begin
      #(20ns * 2000000);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stall, or a long hold-off while hold_off is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // response check at the accepting edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
   end

   // present one request and hold it until accepted; valid stays high
   // after acceptance only when the next request follows at once
   task automatic send_request(input gqi_pkg::req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      requests_sent++;
   endtask

   // wait for every response, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // dt is written only while the block is idle
   task automatic write_period(input logic [31:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.period = v;
   endtask

   function automatic logic [31:0] rand_rate(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(32'h1FF_FFFF) - 32'h100_0000;
         default: return $urandom_range(32'h3FF_FFFF) - 32'h200_0000;
      endcase
   endfunction

   task automatic random_phase(input int count, input int mode);
      gqi_pkg::req_type r;
      repeat (count) begin
         r.rate_x = rand_rate(mode);
         r.rate_y = rand_rate(mode);
         r.rate_z = rand_rate(mode);
         send_request(r);
      end
   endtask

   initial begin
      gqi_pkg::req_type r;
      logic [31:0] extremes[5];
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_off = 1'b0;
      requests_sent = 0;
      send_idle_pct = 31;
      recv_idle_pct = 71;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero rate at reset dt, then field extremes
      extremes = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF};
      r = '0;
      send_request(r);
      foreach (extremes[i]) begin
         r.rate_x = extremes[i];
         r.rate_y = extremes[(i + 1) % 5];
         r.rate_z = extremes[(i + 2) % 5];
         send_request(r);
      end
      // dt zero: identity increment, magnitude drift only
      write_period(32'h0);
      r.rate_x = 32'h7FFF_FFFF; r.rate_y = 32'h8000_0000; r.rate_z = 32'h1234_5678;
      send_request(r);
      // largest dt with saturating rates forces saturation and renormalization
      write_period(32'hFFFF_FFFF);
      foreach (extremes[i]) begin
         r.rate_x = extremes[i];
         r.rate_y = extremes[(i + 3) % 5];
         r.rate_z = extremes[(i + 4) % 5];
         send_request(r);
      end
      // opposite full rates can cancel the quaternion toward zero magnitude
      r.rate_x = 32'h7FFF_FFFF; r.rate_y = 32'h7FFF_FFFF; r.rate_z = 32'h7FFF_FFFF;
      send_request(r);
      r.rate_x = 32'h8000_0000; r.rate_y = 32'h8000_0000; r.rate_z = 32'h8000_0000;
      send_request(r);

      // random phase one: sender 31, receiver 71
      write_period(gqi_pkg::PERIOD_RESET);
      random_phase(120, 1);
      write_period($urandom());
      random_phase(110, 0);

      // random phase two: sender 71, receiver 31, with a long hold-off
      send_idle_pct = 71;
      recv_idle_pct = 31;
      write_period(32'd42949673);
      fork
         random_phase(120, 2);
         begin
            hold_off <= 1'b1;
            repeat (600) @(posedge clock);
            hold_off <= 1'b0;
         end
      join
      write_period(32'h0010_0000);
      random_phase(110, 0);

      // random phase three: no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_period(gqi_pkg::PERIOD_RESET);
      random_phase(120, 1);
      write_period(32'hFFFF_FFFF);
      random_phase(100, 0);

      drain();
      $display("covered %0d requests, %0d responses, %0d renormalized, dt 0 to max",
               requests_sent, board.checked, board.renorm_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
